[rtl/udt_pkg.sv]
// Shared types and codes for the unique key directory table.
package udt_pkg;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 64;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 5;

	typedef enum logic [KIND_W-1:0] {
		K_CREATE,
		K_DELETE,
		K_SEARCH,
		K_LIST
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE,
		ST_FULL,
		ST_EXISTS,
		ST_NOTFOUND,
		ST_EMPTY
	} status_t;

	typedef struct packed {
		logic take_new;
		logic take_upper;
		logic take_head;
	} cell_ctl_t;

endpackage

[rtl/udt_cell.sv]
// One directory cell: a stored key, its compare and its neighbour load.
module udt_cell #(
	parameter int KEY_BITS = 64
) (
	input  logic                clk,
	input  udt_pkg::cell_ctl_t  ctl,
	input  logic                occupied,
	input  logic [KEY_BITS-1:0] cmp_key,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [KEY_BITS-1:0] upper_key,
	input  logic [KEY_BITS-1:0] head_key,
	output logic [KEY_BITS-1:0] stored_key,
	output logic                hit
);
	import udt_pkg::*;

	logic [KEY_BITS-1:0] key_q;

	always_ff @(posedge clk) begin
		if (ctl.take_new) begin
			key_q <= new_key;
		end else if (ctl.take_upper) begin
			key_q <= upper_key;
		end else if (ctl.take_head) begin
			key_q <= head_key;
		end
	end

	assign stored_key = key_q;
	assign hit        = occupied && (key_q == cmp_key);

endmodule

[rtl/unique_key_directory_table_top.sv]
// Top level of the unique key directory table: cell row and sequencer.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | kind, key
//  rsp     | out       | rsp_valid, rsp_stall | status, position, listed_key, last
//
// Create, delete and search pass through S_LOOK, which compares the key against every
// cell and registers the hit vector, then S_EXEC, which updates the cells and loads the response.
// List passes through S_LOOK, then S_LIST: the row rotates one place per response.
// List of an empty table goes through S_EXEC, like create.
// The next request is taken in the cycle that loads the final response.
// Reset clears the entry count and the sequencer registers; cells hold no reset value.
// A stalled response holds the sequencer in S_EXEC or S_LIST and holds the row.
module unique_key_directory_table_top #(
	parameter int MAX_ENTRIES = 32,
	parameter int KEY_BITS    = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [udt_pkg::KIND_W-1:0]     kind,
	input  logic [udt_pkg::KEY_W-1:0]      key,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [udt_pkg::STATUS_W-1:0]   status,
	output logic [udt_pkg::POS_W-1:0]      position,
	output logic [udt_pkg::KEY_W-1:0]      listed_key,
	output logic                           last
);
	import udt_pkg::*;

	localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC,
		S_LIST
	} state_t;

	state_t                 state_q;
	kind_t                  req_kind_q;
	logic [KEY_BITS-1:0]    req_key_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [IDX_BITS-1:0]    list_idx_q;
	logic [MAX_ENTRIES-1:0] hit_q;
	logic                   found_q;
	logic [IDX_BITS-1:0]    pos_q;
	logic                   rsp_valid_q;
	status_t                status_q;
	logic [POS_W-1:0]       position_q;
	logic [KEY_W-1:0]       listed_key_q;
	logic                   last_q;

	logic [KEY_BITS-1:0]    cell_key [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hits;
	logic [MAX_ENTRIES-1:0] occ;
	logic [MAX_ENTRIES-1:0] at_count;
	logic [MAX_ENTRIES-1:0] below_last;
	logic [MAX_ENTRIES-1:0] is_last;
	logic [MAX_ENTRIES-1:0] from_pos;
	logic [IDX_BITS-1:0]    pos_enc;
	logic                   out_free;
	logic                   exec_go;
	logic                   list_go;
	logic                   list_last;
	logic                   fin;
	logic                   req_take;
	logic                   full;
	logic                   do_create;
	logic                   do_delete;
	logic                   rsp_load;
	logic [CNT_BITS-1:0]    list_next;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign exec_go   = (state_q == S_EXEC) && out_free;
	assign list_go   = (state_q == S_LIST) && out_free;
	assign rsp_load  = exec_go || list_go;
	assign list_next = CNT_BITS'(list_idx_q) + CNT_BITS'(1);
	assign list_last = (list_next == count_q);
	assign fin       = exec_go || (list_go && list_last);
	assign req_stall = !((state_q == S_IDLE) || fin);
	assign req_take  = req_valid && !req_stall;
	assign full      = (count_q == CNT_BITS'(MAX_ENTRIES));
	assign do_create = exec_go && (req_kind_q == K_CREATE) && !full && !found_q;
	assign do_delete = exec_go && (req_kind_q == K_DELETE) && found_q;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		localparam logic [CNT_BITS-1:0] IDX_C  = CNT_BITS'(i);
		localparam logic [CNT_BITS-1:0] NEXT_C = CNT_BITS'(i + 1);

		cell_ctl_t           ctl;
		logic [KEY_BITS-1:0] upper;

		assign occ[i]        = count_q > IDX_C;
		assign at_count[i]   = count_q == IDX_C;
		assign below_last[i] = count_q > NEXT_C;
		assign is_last[i]    = count_q == NEXT_C;
		assign from_pos[i]   = |hit_q[i:0];

		if (i < MAX_ENTRIES - 1) begin : g_up
			assign upper = cell_key[i + 1];
		end else begin : g_top
			assign upper = cell_key[i];
		end

		assign ctl.take_new   = do_create && at_count[i];
		assign ctl.take_upper = (do_delete && from_pos[i] && below_last[i]) ||
			(list_go && below_last[i]);
		assign ctl.take_head  = list_go && is_last[i];

		udt_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occ[i]),
			.cmp_key   (req_key_q),
			.new_key   (req_key_q),
			.upper_key (upper),
			.head_key  (cell_key[0]),
			.stored_key(cell_key[i]),
			.hit       (hits[i])
		);
	end

	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (hits[i]) begin
				pos_enc = pos_enc | IDX_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_kind_q   <= K_CREATE;
			req_key_q    <= '0;
			count_q      <= '0;
			list_idx_q   <= '0;
			hit_q        <= '0;
			found_q      <= 1'b0;
			pos_q        <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_DONE;
			position_q   <= '0;
			listed_key_q <= '0;
			last_q       <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			if (req_take) begin
				req_kind_q <= kind_t'(kind);
				req_key_q  <= key[KEY_BITS-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q      <= hits;
					found_q    <= |hits;
					pos_q      <= pos_enc;
					list_idx_q <= '0;
					if (req_kind_q == K_LIST && count_q != '0) begin
						state_q <= S_LIST;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						listed_key_q <= '0;
						last_q       <= 1'b1;
						unique case (req_kind_q)
							K_CREATE: begin
								if (full) begin
									status_q   <= ST_FULL;
									position_q <= '0;
								end else if (found_q) begin
									status_q   <= ST_EXISTS;
									position_q <= '0;
								end else begin
									status_q   <= ST_DONE;
									position_q <= POS_W'(count_q);
									count_q    <= count_q + CNT_BITS'(1);
								end
							end
							K_DELETE: begin
								if (found_q) begin
									status_q   <= ST_DONE;
									position_q <= POS_W'(pos_q);
									count_q    <= count_q - CNT_BITS'(1);
								end else begin
									status_q   <= ST_NOTFOUND;
									position_q <= '0;
								end
							end
							K_SEARCH: begin
								if (found_q) begin
									status_q   <= ST_DONE;
									position_q <= POS_W'(pos_q);
								end else begin
									status_q   <= ST_NOTFOUND;
									position_q <= '0;
								end
							end
							K_LIST: begin
								status_q   <= ST_EMPTY;
								position_q <= '0;
							end
						endcase
						state_q <= req_take ? S_LOOK : S_IDLE;
					end
				end
				S_LIST: begin
					if (list_go) begin
						status_q     <= ST_DONE;
						position_q   <= POS_W'(list_idx_q);
						listed_key_q <= KEY_W'(cell_key[0]);
						last_q       <= list_last;
						list_idx_q   <= list_idx_q + IDX_BITS'(1);
						if (list_last) begin
							state_q <= req_take ? S_LOOK : S_IDLE;
						end
					end
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign position   = position_q;
	assign listed_key = listed_key_q;
	assign last       = last_q;

endmodule

[tb/sv/tb.sv]
// Testbench for the unique key directory table: directed, back-pressure and random request tests.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import udt_pkg::*;

	localparam int DIR_DEPTH = 32;
	localparam int POOL_SIZE = 40;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		status_t            status;
		logic [POS_W-1:0]   pos;
		logic [KEY_W-1:0]   lkey;
		logic               last;
	} reply_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [KIND_W-1:0]   kind = '0;
	logic [KEY_W-1:0]    key = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [KEY_W-1:0]    listed_key;
	logic                last;

	logic [KEY_W-1:0] dir_keys [DIR_DEPTH];
	int               dir_count = 0;
	reply_t           replies_due [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int fail_count = 0;
	int cycle_count = 0;

	unique_key_directory_table_top #(
		.MAX_ENTRIES(DIR_DEPTH),
		.KEY_BITS(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.key(key),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.position(position),
		.listed_key(listed_key),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("unique_key_directory_table_top test failed");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall = 1'b1;
			hold_cycles--;
		end else begin
			rsp_stall = ($urandom_range(99) < stall_pct);
		end
	end

	function automatic int find_slot(input logic [KEY_W-1:0] k);
		for (int i = 0; i < dir_count; i++)
			if (dir_keys[i] == k)
				return i;
		return -1;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		do k = {$urandom, $urandom}; while (find_slot(k) >= 0);
		return k;
	endfunction

	function automatic void push_reply(input status_t st, input int pos,
			input logic [KEY_W-1:0] lkey, input logic fin);
		reply_t r;
		r.status = st;
		r.pos = POS_W'(pos);
		r.lkey = lkey;
		r.last = fin;
		replies_due.push_back(r);
	endfunction

	function automatic void directory_apply(input kind_t op, input logic [KEY_W-1:0] k);
		int hit;
		hit = find_slot(k);
		case (op)
			K_CREATE: begin
				if (dir_count >= DIR_DEPTH) begin
					push_reply(ST_FULL, 0, '0, 1'b1);
				end else if (hit >= 0) begin
					push_reply(ST_EXISTS, 0, '0, 1'b1);
				end else begin
					dir_keys[dir_count] = k;
					push_reply(ST_DONE, dir_count, '0, 1'b1);
					dir_count++;
				end
			end
			K_DELETE: begin
				if (hit < 0) begin
					push_reply(ST_NOTFOUND, 0, '0, 1'b1);
				end else begin
					for (int i = hit; i + 1 < dir_count; i++)
						dir_keys[i] = dir_keys[i + 1];
					dir_count--;
					push_reply(ST_DONE, hit, '0, 1'b1);
				end
			end
			K_SEARCH: begin
				if (hit < 0)
					push_reply(ST_NOTFOUND, 0, '0, 1'b1);
				else
					push_reply(ST_DONE, hit, '0, 1'b1);
			end
			default: begin
				if (dir_count == 0)
					push_reply(ST_EMPTY, 0, '0, 1'b1);
				else
					for (int i = 0; i < dir_count; i++)
						push_reply(ST_DONE, i, dir_keys[i], i == dir_count - 1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (replies_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected reply: status %0d position %0d key %h last %b",
						status, position, listed_key, last);
			end else begin
				exp_r = replies_due.pop_front();
				if (status !== exp_r.status || position !== exp_r.pos ||
						listed_key !== exp_r.lkey || last !== exp_r.last) begin
					fail_count++;
					if (fail_count <= 10) begin
						$write("mismatch: expected status %0d position %0d key %h last %b,",
							exp_r.status, exp_r.pos, exp_r.lkey, exp_r.last);
						$display(" got status %0d position %0d key %h last %b",
							status, position, listed_key, last);
					end
				end
			end
		end
	end

	task automatic send_request(input kind_t op, input logic [KEY_W-1:0] k);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			kind = KIND_W'($urandom);
			key = {$urandom, $urandom};
			@(negedge clk);
		end
		req_valid = 1'b1;
		kind = op;
		key = k;
		do @(posedge clk); while (req_stall);
		directory_apply(op, k);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_ops();
		send_request(K_LIST, '1);
		send_request(K_DELETE, '0);
		send_request(K_SEARCH, '0);
		send_request(K_CREATE, '0);
		send_request(K_CREATE, '1);
		send_request(K_CREATE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(K_CREATE, 64'h5555_5555_5555_5555);
		send_request(K_CREATE, '0);
		send_request(K_SEARCH, '1);
		send_request(K_SEARCH, 64'h6669_6C65_2E74_7874);
		send_request(K_DELETE, 64'h8000_0000_0000_0001);
		send_request(K_LIST, '0);
		send_request(K_DELETE, '0);
		send_request(K_SEARCH, 64'h5555_5555_5555_5555);
		send_request(K_DELETE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(K_LIST, 64'h1234_5678_9ABC_DEF0);
		send_request(K_DELETE, 64'h5555_5555_5555_5555);
		send_request(K_DELETE, '1);
		send_request(K_LIST, '0);
		wait_drain();
	endtask

	task automatic test_full_table_back_pressure();
		hold_cycles = 200;
		while (dir_count < DIR_DEPTH)
			send_request(K_CREATE, fresh_key());
		send_request(K_CREATE, fresh_key());
		send_request(K_CREATE, dir_keys[5]);
		send_request(K_LIST, '0);
		wait_drain();
		send_request(K_DELETE, dir_keys[DIR_DEPTH - 1]);
		send_request(K_DELETE, dir_keys[10]);
		send_request(K_SEARCH, dir_keys[10]);
		send_request(K_DELETE, dir_keys[0]);
		send_request(K_CREATE, fresh_key());
		send_request(K_LIST, '1);
		wait_drain();
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct, input int hold_pct);
		int roll;
		kind_t op;
		logic [KEY_W-1:0] k;
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		repeat (items) begin
			roll = $urandom_range(99);
			if (roll < 35)
				op = K_CREATE;
			else if (roll < 65)
				op = K_DELETE;
			else if (roll < 90)
				op = K_SEARCH;
			else
				op = K_LIST;
			if ($urandom_range(3) == 0)
				k = {$urandom, $urandom};
			else
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			send_request(op, k);
		end
		wait_drain();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed_ops();
		test_full_table_back_pressure();
		test_random_traffic(55, 0, 0);
		test_random_traffic(50, 83, 0);
		test_random_traffic(50, 0, 83);
		test_random_traffic(55, 35, 35);
		@(negedge clk);
		req_valid = 1'b0;
		wait_drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("unique_key_directory_table_top test passed");
		else
			$display("unique_key_directory_table_top test failed");
		$finish;
	end
endmodule
